FILE: rtl/iirdf1_pkg.sv
// iirdf1_pkg: shared types, constants and the microcode program for the
// direct form I IIR filter. Used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package iirdf1_pkg;

  localparam int NUM_TAPS_DEF = 3;
  localparam int DEN_TAPS_DEF = 2;

  localparam int SAMPLE_W = 16;
  localparam int COEF_W   = 24;
  localparam int CFG_IDX_W = 3;
  localparam int MID_W    = 33;          // rounded sum, 25 fraction bits
  localparam int ACC_W    = 43;          // exact sum of products
  localparam int PROD_W   = MID_W + COEF_W;
  localparam int YQ_W     = PROD_W - 30; // result after the final rounding
  localparam int PC_W     = 4;

  localparam logic signed [COEF_W-1:0] COEF_ONE  = 24'sd1048576;
  localparam logic signed [COEF_W-1:0] COEF_ZERO = 24'sd0;

  typedef logic [PC_W-1:0] pc_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_B0  = 3'd0,
    REG_B1  = 3'd1,
    REG_B2  = 3'd2,
    REG_A1  = 3'd3,
    REG_A2  = 3'd4,
    REG_INV = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] b0;
    logic signed [COEF_W-1:0] b1;
    logic signed [COEF_W-1:0] b2;
    logic signed [COEF_W-1:0] a1;
    logic signed [COEF_W-1:0] a2;
    logic signed [COEF_W-1:0] inv_a0;
  } coef_t;

  typedef enum logic [1:0] {
    SRC_NONE,
    SRC_X,
    SRC_Y,
    SRC_MID
  } src_t;

  typedef enum logic [1:0] {
    ACC_NONE,
    ACC_ADD,
    ACC_SUB
  } acc_op_t;

  typedef enum logic [1:0] {
    COND_NONE,
    COND_NUM,
    COND_DEN
  } cond_t;

  typedef enum logic {
    SEQ_IDLE,
    SEQ_RUN
  } seq_state_t;

  // one control word of the program
  typedef struct packed {
    src_t    src;
    logic [1:0] tap;
    acc_op_t pend;
    cond_t   cond;
    pc_t     target;
    logic    mid_ld;
    logic    out_ld;
  } ctrl_t;

  localparam ctrl_t CTRL_NOP = '{SRC_NONE, 2'd0, ACC_NONE, COND_NONE, 4'd0, 1'b0, 1'b0};

  localparam pc_t PC_FB    = 4'd3;
  localparam pc_t PC_FLUSH = 4'd5;
  localparam pc_t PC_LAST  = 4'd8;

  function automatic ctrl_t mk_word(src_t src, logic [1:0] tap, acc_op_t pend,
                                    cond_t cond, pc_t target, logic mid_ld,
                                    logic out_ld);
    ctrl_t w;
    w.src    = src;
    w.tap    = tap;
    w.pend   = pend;
    w.cond   = cond;
    w.target = target;
    w.mid_ld = mid_ld;
    w.out_ld = out_ld;
    return w;
  endfunction

  // program: feed-forward taps, feedback taps, settle, round, scale, output
  function automatic ctrl_t ucode(pc_t pc);
    ctrl_t w;
    w = CTRL_NOP;
    unique case (pc)
      4'd0: w = mk_word(SRC_X, 2'd0, ACC_ADD, COND_NONE, 4'd0, 1'b0, 1'b0);
      4'd1: w = mk_word(SRC_X, 2'd1, ACC_ADD, COND_NUM, PC_FB, 1'b0, 1'b0);
      4'd2: w = mk_word(SRC_X, 2'd2, ACC_ADD, COND_NUM, PC_FB, 1'b0, 1'b0);
      4'd3: w = mk_word(SRC_Y, 2'd0, ACC_SUB, COND_NONE, 4'd0, 1'b0, 1'b0);
      4'd4: w = mk_word(SRC_Y, 2'd1, ACC_SUB, COND_DEN, PC_FLUSH, 1'b0, 1'b0);
      4'd5: w = CTRL_NOP;
      4'd6: w = mk_word(SRC_NONE, 2'd0, ACC_NONE, COND_NONE, 4'd0, 1'b1, 1'b0);
      4'd7: w = mk_word(SRC_MID, 2'd0, ACC_NONE, COND_NONE, 4'd0, 1'b0, 1'b0);
      4'd8: w = mk_word(SRC_NONE, 2'd0, ACC_NONE, COND_NONE, 4'd0, 1'b0, 1'b1);
      default: w = CTRL_NOP;
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/iirdf1_seq.sv
// iirdf1_seq: step counter and microcode sequencer with conditional skips.
// Depends on iirdf1_pkg for the program and the control word type.
`timescale 1ns / 1ps
`default_nettype none

module iirdf1_seq #(
  parameter int NUM_TAPS = iirdf1_pkg::NUM_TAPS_DEF,
  parameter int DEN_TAPS = iirdf1_pkg::DEN_TAPS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic              out_hold,
  output iirdf1_pkg::ctrl_t      ctrl,
  output logic                   busy
);
  import iirdf1_pkg::*;

  seq_state_t state, state_next;
  pc_t        pc, pc_next;
  ctrl_t      word;
  logic       taken;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SEQ_IDLE;
      pc    <= '0;
    end else begin
      state <= state_next;
      pc    <= pc_next;
    end
  end

  always_comb begin
    word       = ucode(pc);
    state_next = state;
    pc_next    = pc;
    ctrl       = CTRL_NOP;
    taken      = 1'b0;
    unique case (word.cond)
      COND_NUM: taken = int'(word.tap) >= NUM_TAPS;
      COND_DEN: taken = int'(word.tap) >= DEN_TAPS;
      default:  taken = 1'b0;
    endcase
    unique case (state)
      SEQ_IDLE: begin
        if (start) begin
          state_next = SEQ_RUN;
          pc_next    = '0;
        end
      end
      SEQ_RUN: begin
        if (taken) begin
          pc_next = word.target;
        end else if (word.out_ld) begin
          // wait while the previous result still sits in the output register
          if (!out_hold) begin
            ctrl       = word;
            state_next = SEQ_IDLE;
            pc_next    = '0;
          end
        end else begin
          ctrl    = word;
          pc_next = pc + 1'b1;
        end
      end
      default: state_next = SEQ_IDLE;
    endcase
  end

  assign busy = (state == SEQ_RUN);

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> state == SEQ_IDLE) else $error("start while running");
  a_pc_range: assert property (@(posedge clk) disable iff (rst)
    state == SEQ_RUN |-> pc <= PC_LAST) else $error("step counter out of program");
  a_out_ends: assert property (@(posedge clk) disable iff (rst)
    ctrl.out_ld |=> state == SEQ_IDLE) else $error("sequencer ran past output step");

endmodule

`default_nettype wire

FILE: rtl/iirdf1_dp.sv
// iirdf1_dp: sample delay lines, shared multiplier, accumulator, rounding,
// saturation and output register. Depends on iirdf1_pkg.
`timescale 1ns / 1ps
`default_nettype none

module iirdf1_dp #(
  parameter int NUM_TAPS = iirdf1_pkg::NUM_TAPS_DEF,
  parameter int DEN_TAPS = iirdf1_pkg::DEN_TAPS_DEF
) (
  input  wire logic                                     clk,
  input  wire logic                                     rst,
  input  wire logic                                     start,
  input  wire logic signed [iirdf1_pkg::SAMPLE_W-1:0]   sample_in,
  input  wire iirdf1_pkg::ctrl_t                        ctrl,
  input  wire iirdf1_pkg::coef_t                        coef,
  input  wire logic                                     out_stall,
  output logic                                          out_valid,
  output logic signed [iirdf1_pkg::SAMPLE_W-1:0]        sample_out,
  output logic                                          saturated
);
  import iirdf1_pkg::*;

  logic signed [SAMPLE_W-1:0] xh [NUM_TAPS];
  logic signed [SAMPLE_W-1:0] yh [DEN_TAPS];

  logic signed [MID_W-1:0]  op_a;
  logic signed [COEF_W-1:0] op_b;
  logic signed [PROD_W-1:0] prod;
  acc_op_t                  pend;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  acc_rnd;
  logic signed [MID_W-1:0]  mid;
  logic signed [PROD_W-1:0] y_rnd;
  logic signed [YQ_W-1:0]   y_q;
  logic signed [SAMPLE_W-1:0] y_sat;
  logic                     y_clip;

  // operand select for the shared multiplier
  always_comb begin
    op_a = '0;
    op_b = '0;
    case (ctrl.src)
      SRC_X: begin
        for (int i = 0; i < NUM_TAPS; i++) begin
          if (int'(ctrl.tap) == i) op_a = MID_W'(xh[i]);
        end
        case (ctrl.tap)
          2'd0:    op_b = coef.b0;
          2'd1:    op_b = coef.b1;
          2'd2:    op_b = coef.b2;
          default: op_b = '0;
        endcase
      end
      SRC_Y: begin
        for (int i = 0; i < DEN_TAPS; i++) begin
          if (int'(ctrl.tap) == i) op_a = MID_W'(yh[i]);
        end
        case (ctrl.tap)
          2'd0:    op_b = coef.a1;
          2'd1:    op_b = coef.a2;
          default: op_b = '0;
        endcase
      end
      SRC_MID: begin
        op_a = mid;
        op_b = coef.inv_a0;
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  // round half up to 25 fraction bits, then to 15 after scaling
  always_comb begin
    acc_rnd = acc + ACC_W'(512);
    y_rnd   = prod + (PROD_W'(1) << 29);
    y_q     = y_rnd[PROD_W-1:30];
    y_clip  = 1'b0;
    y_sat   = y_q[SAMPLE_W-1:0];
    if (y_q > YQ_W'(32767)) begin
      y_sat  = 16'sh7fff;
      y_clip = 1'b1;
    end else if (y_q < -YQ_W'(32768)) begin
      y_sat  = -16'sh8000;
      y_clip = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.src != SRC_NONE) prod <= op_a * op_b;
    if (ctrl.mid_ld) mid <= acc_rnd[ACC_W-1:10];
    if (start) begin
      acc <= '0;
    end else if (pend == ACC_ADD) begin
      acc <= acc + prod[ACC_W-1:0];
    end else if (pend == ACC_SUB) begin
      acc <= acc - prod[ACC_W-1:0];
    end
    if (ctrl.out_ld) begin
      sample_out <= y_sat;
      saturated  <= y_clip;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend      <= ACC_NONE;
      out_valid <= 1'b0;
      for (int i = 0; i < NUM_TAPS; i++) xh[i] <= '0;
      for (int i = 0; i < DEN_TAPS; i++) yh[i] <= '0;
    end else begin
      pend <= ctrl.pend;
      if (ctrl.out_ld) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (start) begin
        xh[0] <= sample_in;
        for (int i = 1; i < NUM_TAPS; i++) xh[i] <= xh[i-1];
      end
      // clipped value is the one fed back
      if (ctrl.out_ld) begin
        yh[0] <= y_sat;
        for (int i = 1; i < DEN_TAPS; i++) yh[i] <= yh[i-1];
      end
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    ctrl.out_ld |-> !(out_valid && out_stall)) else $error("result overwritten");
  a_acc_settled: assert property (@(posedge clk) disable iff (rst)
    ctrl.mid_ld |-> pend == ACC_NONE) else $error("rounding before sum settled");
  a_start_clean: assert property (@(posedge clk) disable iff (rst)
    start |-> pend == ACC_NONE && ctrl.src == SRC_NONE) else $error("start mid-item");

endmodule

`default_nettype wire

FILE: rtl/iir_direct_form_one_filter.sv
// iir_direct_form_one_filter: top level, coefficient registers, sequencer
// and datapath. Depends on iirdf1_pkg, iirdf1_seq and iirdf1_dp.
//
//   channel  direction  handshake              payload
//   input    in         in_valid / in_stall    sample_in
//   output   out        out_valid / out_stall  sample_out, saturated
//   config   in         cfg_we                 cfg_index, cfg_data
//
// an item's result is computed by a nine-step program that drives the one
// shared multiplier (five taps, settle, round, scale, output)
// in_stall stays high while the program runs; the next item is taken the
// cycle after the output step, so only one item runs through the program at a time
// a new item is taken while a result waits; its output step waits on out_stall
// rst is synchronous: delay lines clear, coefficients return to b0 = 1.0,
// inv_a0 = 1.0, others zero
`timescale 1ns / 1ps
`default_nettype none

module iir_direct_form_one_filter #(
  parameter int NUM_TAPS = iirdf1_pkg::NUM_TAPS_DEF,
  parameter int DEN_TAPS = iirdf1_pkg::DEN_TAPS_DEF
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  input  wire logic                                    in_valid,
  output logic                                         in_stall,
  input  wire logic signed [iirdf1_pkg::SAMPLE_W-1:0]  sample_in,
  output logic                                         out_valid,
  input  wire logic                                    out_stall,
  output logic signed [iirdf1_pkg::SAMPLE_W-1:0]       sample_out,
  output logic                                         saturated,
  input  wire logic                                    cfg_we,
  input  wire logic [iirdf1_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [iirdf1_pkg::COEF_W-1:0]           cfg_data
);
  import iirdf1_pkg::*;

  coef_t coef;
  ctrl_t ctrl;
  logic  busy;
  logic  start;
  logic  out_hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef.b0     <= COEF_ONE;
      coef.b1     <= COEF_ZERO;
      coef.b2     <= COEF_ZERO;
      coef.a1     <= COEF_ZERO;
      coef.a2     <= COEF_ZERO;
      coef.inv_a0 <= COEF_ONE;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_B0:  coef.b0     <= cfg_data;
        REG_B1:  coef.b1     <= cfg_data;
        REG_B2:  coef.b2     <= cfg_data;
        REG_A1:  coef.a1     <= cfg_data;
        REG_A2:  coef.a2     <= cfg_data;
        REG_INV: coef.inv_a0 <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_stall = busy;
  assign start    = in_valid && !busy;
  assign out_hold = out_valid && out_stall;

  iirdf1_seq #(
    .NUM_TAPS(NUM_TAPS),
    .DEN_TAPS(DEN_TAPS)
  ) u_seq (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .out_hold (out_hold),
    .ctrl     (ctrl),
    .busy     (busy)
  );

  iirdf1_dp #(
    .NUM_TAPS(NUM_TAPS),
    .DEN_TAPS(DEN_TAPS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .sample_in  (sample_in),
    .ctrl       (ctrl),
    .coef       (coef),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .sample_out (sample_out),
    .saturated  (saturated)
  );

endmodule

`default_nettype wire

FILE: bench/tb.sv
// tb: self-checking bench for iir_direct_form_one_filter, a directed script of samples
// and register writes followed by random coefficient phases, against an internal predictor
// depends on iirdf1_pkg and iir_direct_form_one_filter
`timescale 1ns / 1ps

module tb;
  import iirdf1_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int TAIL_CYCLES    = 24;
  localparam int NUM_PHASES     = 10;
  localparam int PHASE_ITEMS    = 100;
  localparam int NUM_ROWS       = 41;
  localparam int SUM_SHIFT      = 10;
  localparam int OUT_SHIFT      = 30;
  localparam int SAMPLE_MAX     = 32767;
  localparam int SAMPLE_MIN     = -32768;

  // indexes past the last register, writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_kind_t;
  typedef enum logic [1:0] {STALL_NONE, STALL_SPARSE, STALL_LONG} stall_mode_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] value;
    logic                       clipped;
  } filtered_t;

  typedef struct packed {
    row_kind_t                  kind;
    logic [CFG_IDX_W-1:0]       idx;
    logic [COEF_W-1:0]          data;
    logic signed [SAMPLE_W-1:0] x;
    logic                       typed;
    filtered_t                  want;
  } script_row_t;

  logic                       clk;
  logic                       rst;
  logic                       in_valid;
  logic                       in_stall;
  logic signed [SAMPLE_W-1:0] sample_in;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic signed [SAMPLE_W-1:0] sample_out;
  logic                       saturated;
  logic                       cfg_we;
  logic [CFG_IDX_W-1:0]       cfg_index;
  logic [COEF_W-1:0]          cfg_data;

  // predictor state: coefficients and the two delay lines as shift registers
  coef_t                      coefs;
  logic signed [SAMPLE_W-1:0] x_d1, x_d2, y_d1, y_d2;

  filtered_t   due_outputs[$];
  filtered_t   head;
  int          mismatch_count = 0;
  int          idle_cycles    = 0;
  int          burst_left     = 0;
  int          stall_left     = 0;
  stall_mode_t stall_mode     = STALL_NONE;

  iir_direct_form_one_filter i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .sample_in  (sample_in),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .sample_out (sample_out),
    .saturated  (saturated),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  function automatic script_row_t set_reg_row(logic [CFG_IDX_W-1:0] idx,
                                              logic [COEF_W-1:0] data);
    return '{ROW_WRITE, idx, data, '0, 1'b0, '0};
  endfunction

  function automatic script_row_t sample_row(logic signed [SAMPLE_W-1:0] x);
    return '{ROW_SAMPLE, '0, '0, x, 1'b0, '0};
  endfunction

  function automatic script_row_t known_row(logic signed [SAMPLE_W-1:0] x,
                                            logic signed [SAMPLE_W-1:0] y, logic sat);
    return '{ROW_SAMPLE, '0, '0, x, 1'b1, '{y, sat}};
  endfunction

  script_row_t script [NUM_ROWS] = '{
    // reset coefficients pass the sample straight through
    known_row(16'sd32767, 16'sd32767, 1'b0),
    known_row(-16'sd32768, -16'sd32768, 1'b0),
    known_row(16'sd0, 16'sd0, 1'b0),
    known_row(16'sd1, 16'sd1, 1'b0),
    known_row(-16'sd1, -16'sd1, 1'b0),
    known_row(16'sd21845, 16'sd21845, 1'b0),
    known_row(-16'sd21846, -16'sd21846, 1'b0),
    // largest gain clips both ways
    set_reg_row(REG_B0, 24'h7FFFFF),
    known_row(16'sd32767, 16'sd32767, 1'b1),
    known_row(-16'sd32768, -16'sd32768, 1'b1),
    known_row(16'sd0, 16'sd0, 1'b0),
    // most negative gain, -8.0
    set_reg_row(REG_B0, 24'h800000),
    known_row(16'sd1, -16'sd8, 1'b0),
    known_row(-16'sd32768, 16'sd32767, 1'b1),
    known_row(16'sd32767, -16'sd32768, 1'b1),
    // a mild second-order section and its response to a two-sample input
    set_reg_row(REG_B0, 24'h100000),
    set_reg_row(REG_B1, 24'h080000),
    set_reg_row(REG_B2, 24'hFC0000),
    set_reg_row(REG_A1, 24'hF33333),
    set_reg_row(REG_A2, 24'h04CCCD),
    sample_row(16'sd10000),
    sample_row(-16'sd5000),
    sample_row(16'sd0),
    sample_row(16'sd0),
    sample_row(16'sd0),
    // writes beyond the register file change nothing
    set_reg_row(CFG_SPARE_LO, 24'hFFFFFF),
    set_reg_row(CFG_SPARE_HI, 24'h800000),
    sample_row(16'sd0),
    // reciprocal extremes, clipped values are fed back
    set_reg_row(REG_INV, 24'h7FFFFF),
    sample_row(16'sd32767),
    sample_row(-16'sd32768),
    set_reg_row(REG_INV, 24'h800000),
    sample_row(16'sd1000),
    sample_row(-16'sd1),
    // every tap but b0 at an extreme
    set_reg_row(REG_B1, 24'h7FFFFF),
    set_reg_row(REG_B2, 24'h800000),
    set_reg_row(REG_A1, 24'h7FFFFF),
    set_reg_row(REG_A2, 24'h800000),
    sample_row(16'sd32767),
    sample_row(-16'sd32768),
    sample_row(16'sd12345)
  };

  function automatic void load_coef(logic [CFG_IDX_W-1:0] idx, logic [COEF_W-1:0] val);
    case (idx)
      REG_B0:  coefs.b0 = val;
      REG_B1:  coefs.b1 = val;
      REG_B2:  coefs.b2 = val;
      REG_A1:  coefs.a1 = val;
      REG_A2:  coefs.a2 = val;
      REG_INV: coefs.inv_a0 = val;
      default: ;
    endcase
  endfunction

  // one direct form I step: exact sum, round to 25 fraction bits, scale, round, clip
  function automatic filtered_t iir_predict(logic signed [SAMPLE_W-1:0] x);
    longint    acc;
    longint    mid;
    longint    y;
    filtered_t r;
    acc = longint'(x) * longint'(coefs.b0) + longint'(x_d1) * longint'(coefs.b1)
        + longint'(x_d2) * longint'(coefs.b2) - longint'(y_d1) * longint'(coefs.a1)
        - longint'(y_d2) * longint'(coefs.a2);
    mid = (acc + (longint'(1) << (SUM_SHIFT - 1))) >>> SUM_SHIFT;
    y = (mid * longint'(coefs.inv_a0) + (longint'(1) << (OUT_SHIFT - 1))) >>> OUT_SHIFT;
    r.clipped = 1'b0;
    if (y > SAMPLE_MAX) begin
      y = SAMPLE_MAX;
      r.clipped = 1'b1;
    end else if (y < SAMPLE_MIN) begin
      y = SAMPLE_MIN;
      r.clipped = 1'b1;
    end
    r.value = SAMPLE_W'(y);
    x_d2 = x_d1;
    x_d1 = x;
    y_d2 = y_d1;
    y_d1 = r.value;
    return r;
  endfunction

  function automatic logic [COEF_W-1:0] pick_coef(bit tame);
    case ($urandom_range(0, tame ? 19 : 5))
      0:       return 24'h7FFFFF;
      1:       return 24'h800000;
      2:       return '0;
      default: return tame ? COEF_W'($urandom_range(0, 2 ** 21) - 2 ** 20)
                           : COEF_W'($urandom());
    endcase
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2, 3:    return SAMPLE_W'($urandom_range(0, 511) - 256);
      default: return SAMPLE_W'($urandom());
    endcase
  endfunction

  // block the sender and wait for every result in flight
  task automatic drain();
    in_valid <= 1'b0;
    while (due_outputs.size() != 0) @(posedge clk);
  endtask

  task automatic program_reg(logic [CFG_IDX_W-1:0] idx, logic [COEF_W-1:0] val);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    load_coef(idx, val);
  endtask

  task automatic send_sample(logic signed [SAMPLE_W-1:0] x, logic typed, filtered_t want);
    filtered_t guess;
    cfg_we <= 1'b0;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200)
                                               : $urandom_range(1, 12);
    end
    burst_left--;
    in_valid  <= 1'b1;
    sample_in <= x;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    guess = iir_predict(x);
    due_outputs.push_back(typed ? want : guess);
  endtask

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // receiver stall pattern: calm, sparse, and long-run modes
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= stall_mode_t'($urandom_range(0, 2));
      stall_left <= $urandom_range(20, 150);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      STALL_NONE:   out_stall <= 1'b0;
      STALL_SPARSE: out_stall <= ($urandom_range(0, 3) == 0);
      default:      out_stall <= ($urandom_range(0, 15) == 0) ? !out_stall : out_stall;
    endcase
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (due_outputs.size() == 0) begin
        $error("unexpected item: sample_out %0d saturated %0b", sample_out, saturated);
        mismatch_count++;
      end else begin
        head = due_outputs.pop_front();
        if (sample_out !== head.value) begin
          $error("sample_out: expected %0d, got %0d", head.value, sample_out);
          mismatch_count++;
        end
        if (saturated !== head.clipped) begin
          $error("saturated: expected %0b, got %0b", head.clipped, saturated);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("iir_direct_form_one_filter regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    bit tame;
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    sample_in <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    coefs = '{COEF_ONE, COEF_ZERO, COEF_ZERO, COEF_ZERO, COEF_ZERO, COEF_ONE};
    x_d1 = '0;
    x_d2 = '0;
    y_d1 = '0;
    y_d2 = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (script[i]) begin
      if (script[i].kind == ROW_WRITE) begin
        program_reg(script[i].idx, script[i].data);
      end else begin
        send_sample(script[i].x, script[i].typed, script[i].want);
      end
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      tame = ($urandom_range(0, 2) != 0);
      for (int k = 0; k < REG_INV; k++) program_reg(CFG_IDX_W'(k), pick_coef(tame));
      program_reg(REG_INV, tame ? COEF_W'(32'd1048576 + $urandom_range(0, 2 ** 19) - 2 ** 18)
                                : pick_coef(1'b0));
      if ($urandom_range(0, 3) == 0) begin
        program_reg($urandom_range(0, 1) ? CFG_SPARE_HI : CFG_SPARE_LO, COEF_W'($urandom()));
      end
      for (int n = 0; n < PHASE_ITEMS; n++) send_sample(pick_sample(), 1'b0, '0);
    end

    cfg_we <= 1'b0;
    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("iir_direct_form_one_filter regression: pass");
    end else begin
      $display("iir_direct_form_one_filter regression: fail");
    end
    $finish;
  end

endmodule
